>>> design/rfr_pkg.sv
package rfr_pkg;

  // Frame format constants.
  localparam logic [15:0] FC_WORD   = 16'h0001 | (16'h1 << 6) | (16'h2 << 14) | (16'h2 << 10);
  localparam logic [15:0] BCAST_ADDR = 16'hFFFF;
  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned CRC_BYTES = 2;
  localparam int unsigned STORE_DEPTH = 15;
  localparam int unsigned BODY_BYTES = 25;
  localparam int unsigned TS_BYTES = 5;

  // Payload bytes kept in the reply for each accepted sequence number.
  localparam int unsigned KEEP_SEQ0 = 5;
  localparam int unsigned KEEP_SEQ1 = 15;

  // Header byte positions of a received or transmitted frame.
  localparam logic [5:0] POS_FC_LO  = 6'd0;
  localparam logic [5:0] POS_FC_HI  = 6'd1;
  localparam logic [5:0] POS_SEQ    = 6'd2;
  localparam logic [5:0] POS_PAN_LO = 6'd3;
  localparam logic [5:0] POS_PAN_HI = 6'd4;
  localparam logic [5:0] POS_DST_LO = 6'd5;
  localparam logic [5:0] POS_DST_HI = 6'd6;
  localparam logic [5:0] POS_SRC_LO = 6'd7;
  localparam logic [5:0] POS_SRC_HI = 6'd8;
  localparam logic [5:0] POS_MAX    = 6'd63;

  // Smallest last-byte position that still holds the whole reply payload and CRC.
  localparam logic [5:0] MIN_LAST_SEQ0 = 6'(HDR_BYTES + KEEP_SEQ0 + CRC_BYTES - 1);
  localparam logic [5:0] MIN_LAST_SEQ1 = 6'(HDR_BYTES + KEEP_SEQ1 + CRC_BYTES - 1);

  // Sequence numbers that get a reply.
  localparam logic [7:0] SEQ_SHORT = 8'd0;
  localparam logic [7:0] SEQ_LONG  = 8'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_PAN_ID      = 2'd0;
  localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
  localparam logic [1:0] REG_REPLY_DELAY = 2'd2;
  localparam logic [31:0] REPLY_DELAY_RST = 32'd1000;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One transmit job handed from the front to the back.
  typedef struct packed {
    logic [7:0]                   seq;
    logic [15:0]                  dst;
    logic [BODY_BYTES-1:0][7:0]   body;
    logic [4:0]                   body_len;
    logic [39:0]                  tx_time;
  } rfr_job_t;

endpackage

>>> design/rfr_front.sv
module rfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              command,
  input  logic [7:0]        rx_byte,
  input  logic              rx_last,
  input  logic [39:0]       timestamp,
  input  logic [15:0]       pan_id,
  input  logic [15:0]       own_address,
  input  logic [31:0]       reply_delay,
  output logic              push,
  output rfr_pkg::rfr_job_t job
);

  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] pan_r, pan_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic [15:0] src_r, src_nxt;
  logic [7:0]  store_r [rfr_pkg::STORE_DEPTH];
  logic        store_we;
  logic [3:0]  store_addr;
  logic [5:0]  store_off;
  logic [39:0] tx_sum;
  logic        addr_ok;
  logic        len_ok;

  // Header capture and byte counter.
  always_comb begin
    pos_nxt = pos_r;
    seq_nxt = seq_r;
    pan_nxt = pan_r;
    dst_nxt = dst_r;
    src_nxt = src_r;
    if (accept && !command) begin
      case (pos_r)
        rfr_pkg::POS_SEQ:    seq_nxt = rx_byte;
        rfr_pkg::POS_PAN_LO: pan_nxt = {pan_r[15:8], rx_byte};
        rfr_pkg::POS_PAN_HI: pan_nxt = {rx_byte, pan_r[7:0]};
        rfr_pkg::POS_DST_LO: dst_nxt = {dst_r[15:8], rx_byte};
        rfr_pkg::POS_DST_HI: dst_nxt = {rx_byte, dst_r[7:0]};
        rfr_pkg::POS_SRC_LO: src_nxt = {src_r[15:8], rx_byte};
        rfr_pkg::POS_SRC_HI: src_nxt = {rx_byte, src_r[7:0]};
        default: ;
      endcase
      if (rx_last) begin
        pos_nxt = '0;
      end else if (pos_r != rfr_pkg::POS_MAX) begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      seq_r <= '0;
      pan_r <= '0;
      dst_r <= '0;
      src_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      seq_r <= seq_nxt;
      pan_r <= pan_nxt;
      dst_r <= dst_nxt;
      src_r <= src_nxt;
    end
  end

  // Payload capture: the first payload bytes of the frame.
  assign store_off  = pos_r - 6'(rfr_pkg::HDR_BYTES);
  assign store_addr = store_off[3:0];
  assign store_we   = accept && !command
                      && (pos_r >= 6'(rfr_pkg::HDR_BYTES))
                      && (pos_r < 6'(rfr_pkg::HDR_BYTES + rfr_pkg::STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_addr] <= rx_byte;
    end
  end

  // Classification at the last byte; the final byte never lands in the kept payload.
  assign tx_sum  = timestamp + {8'd0, reply_delay};
  assign addr_ok = (pan_r == pan_id) && ((dst_r == own_address) || (dst_r == rfr_pkg::BCAST_ADDR));
  assign len_ok  = ((seq_r == rfr_pkg::SEQ_SHORT) && (pos_r >= rfr_pkg::MIN_LAST_SEQ0))
                   || ((seq_r == rfr_pkg::SEQ_LONG) && (pos_r >= rfr_pkg::MIN_LAST_SEQ1));
  assign push    = accept && (command || (rx_last && addr_ok && len_ok));

  // Job body: kept payload, then rx and tx times big-endian; command: tx time only.
  always_comb begin
    job          = '0;
    job.tx_time  = tx_sum;
    if (command) begin
      job.seq      = '0;
      job.dst      = rfr_pkg::BCAST_ADDR;
      job.body_len = 5'(rfr_pkg::TS_BYTES);
      for (int k = 0; k < rfr_pkg::TS_BYTES; k++) begin
        job.body[k] = tx_sum[39-8*k -: 8];
      end
    end else if (seq_r == rfr_pkg::SEQ_SHORT) begin
      job.seq      = seq_r + 8'd1;
      job.dst      = src_r;
      job.body_len = 5'(rfr_pkg::KEEP_SEQ0 + 2 * rfr_pkg::TS_BYTES);
      for (int k = 0; k < rfr_pkg::KEEP_SEQ0; k++) begin
        job.body[k] = store_r[k];
      end
      for (int k = 0; k < rfr_pkg::TS_BYTES; k++) begin
        job.body[rfr_pkg::KEEP_SEQ0 + k] = timestamp[39-8*k -: 8];
        job.body[rfr_pkg::KEEP_SEQ0 + rfr_pkg::TS_BYTES + k] = tx_sum[39-8*k -: 8];
      end
    end else begin
      job.seq      = seq_r + 8'd1;
      job.dst      = src_r;
      job.body_len = 5'(rfr_pkg::KEEP_SEQ1 + 2 * rfr_pkg::TS_BYTES);
      for (int k = 0; k < rfr_pkg::KEEP_SEQ1; k++) begin
        job.body[k] = store_r[k];
      end
      for (int k = 0; k < rfr_pkg::TS_BYTES; k++) begin
        job.body[rfr_pkg::KEEP_SEQ1 + k] = timestamp[39-8*k -: 8];
        job.body[rfr_pkg::KEEP_SEQ1 + rfr_pkg::TS_BYTES + k] = tx_sum[39-8*k -: 8];
      end
    end
  end

endmodule

>>> design/rfr_queue.sv
module rfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rfr_pkg::rfr_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output rfr_pkg::rfr_job_t head
);

  rfr_pkg::rfr_job_t entry_r [rfr_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'(rfr_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // The front must never write a full queue, nor the back drain an empty one.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'(rfr_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count missed a write");

endmodule

>>> design/rfr_back.sv
module rfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  rfr_pkg::rfr_job_t job,
  input  logic [15:0]       pan_id,
  input  logic [15:0]       own_address,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [39:0]       out_time
);

  logic [5:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [39:0] time_r;
  logic        load;
  logic [5:0]  body_end;
  logic [5:0]  last_idx;
  logic [5:0]  body_off;
  logic [7:0]  cur_byte;
  logic        cur_last;

  assign body_end = 6'(rfr_pkg::HDR_BYTES) + {1'b0, job.body_len};
  assign last_idx = body_end + 6'(rfr_pkg::CRC_BYTES - 1);
  assign body_off = idx_r - 6'(rfr_pkg::HDR_BYTES);
  assign cur_last = (idx_r == last_idx);

  // Byte of the current job at the current position.
  always_comb begin
    case (idx_r)
      rfr_pkg::POS_FC_LO:  cur_byte = rfr_pkg::FC_WORD[7:0];
      rfr_pkg::POS_FC_HI:  cur_byte = rfr_pkg::FC_WORD[15:8];
      rfr_pkg::POS_SEQ:    cur_byte = job.seq;
      rfr_pkg::POS_PAN_LO: cur_byte = pan_id[7:0];
      rfr_pkg::POS_PAN_HI: cur_byte = pan_id[15:8];
      rfr_pkg::POS_DST_LO: cur_byte = job.dst[7:0];
      rfr_pkg::POS_DST_HI: cur_byte = job.dst[15:8];
      rfr_pkg::POS_SRC_LO: cur_byte = own_address[7:0];
      rfr_pkg::POS_SRC_HI: cur_byte = own_address[15:8];
      default: begin
        if (idx_r < body_end) begin
          cur_byte = job.body[body_off[4:0]];
        end else begin
          cur_byte = 8'h00;
        end
      end
    endcase
  end

  // The output register takes a new byte whenever a job is present and the register is empty or being drained.
  assign load = job_valid && (!valid_r || out_ready);
  assign pop  = load && cur_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = cur_last ? 6'd0 : idx_r + 6'd1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
      time_r <= job.tx_time;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_time  = time_r;

  // The byte position only runs while a job is present and never passes its end.
  assert property (@(posedge clk) disable iff (!rst_n) !job_valid |-> idx_r == 6'd0)
    else $error("position counter running without a job");
  assert property (@(posedge clk) disable iff (!rst_n) job_valid |-> idx_r <= last_idx)
    else $error("position past frame end");
  assert property (@(posedge clk) disable iff (!rst_n) (valid_r && !out_ready) |=> valid_r)
    else $error("output byte dropped while stalled");

endmodule

>>> design/ranging_frame_responder.sv
// Ranging frame responder: parses received frames and emits reply or advertisement frames.
// Throughput: one input byte per cycle while the two-entry job queue has room.
// With the back end idle, the job made by the last frame byte (or command) is written
// into the queue and then loaded into the output register that drives out_tvalid;
// then it sends one byte per cycle while out_tready is high: 16, 26 or 36 bytes a frame.
// Reset (rst_n low, synchronous) clears the byte counter, header fields, queue and output;
// registers return to PAN 0, address 0 and a reply delay of 1000 ticks.
module ranging_frame_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [7:0] rx_byte, [47:8] timestamp
  input  logic        in_tlast,   // rx_last
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] tx_byte, [47:8] tx_time
  output logic        out_tlast,  // tx_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0]       pan_id_r;
  logic [15:0]       own_address_r;
  logic [31:0]       reply_delay_r;
  logic              accept;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_not_empty;
  rfr_pkg::rfr_job_t push_job;
  rfr_pkg::rfr_job_t head_job;
  logic [7:0]        tx_byte;
  logic [39:0]       tx_time;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_id_r      <= '0;
      own_address_r <= '0;
      reply_delay_r <= rfr_pkg::REPLY_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfr_pkg::REG_PAN_ID:      pan_id_r      <= cfg_data[15:0];
        rfr_pkg::REG_OWN_ADDRESS: own_address_r <= cfg_data[15:0];
        rfr_pkg::REG_REPLY_DELAY: reply_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // An input transfer is taken whenever the queue can hold a job it might create.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  rfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_tuser),
    .rx_byte     (in_tdata[7:0]),
    .rx_last     (in_tlast),
    .timestamp   (in_tdata[47:8]),
    .pan_id      (pan_id_r),
    .own_address (own_address_r),
    .reply_delay (reply_delay_r),
    .push        (push),
    .job         (push_job)
  );

  rfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  rfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (q_not_empty),
    .job         (head_job),
    .pan_id      (pan_id_r),
    .own_address (own_address_r),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (tx_byte),
    .out_last    (out_tlast),
    .out_time    (tx_time)
  );

  assign out_tdata = {tx_time, tx_byte};

endmodule

>>> tb/ranging_frame_responder_test.sv
`timescale 1ns / 1ps

module ranging_frame_responder_test;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned FRAME_MAX = rfr_pkg::HDR_BYTES + rfr_pkg::BODY_BYTES
                                      + rfr_pkg::CRC_BYTES;
  localparam int NO_ADVERT = -1;

  // One transmitted byte as it should appear on the result stream.
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [39:0] tx_time;
  } tx_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rfr_pkg::REG_PAN_ID;
  logic [31:0] cfg_data = '0;

  ranging_frame_responder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mirror of the responder state and registers.
  logic [15:0] cur_pan_id;
  logic [15:0] cur_own_addr;
  logic [31:0] cur_delay;
  logic [5:0]  rx_pos;
  logic [7:0]  rx_seq;
  logic [15:0] rx_pan;
  logic [15:0] rx_dst;
  logic [15:0] rx_src;
  logic [7:0]  rx_payload [rfr_pkg::STORE_DEPTH];
  tx_beat_t    tx_bytes_due [$];

  // Run bookkeeping.
  int          items_sent = 0;
  int          replies_due = 0;
  int          adverts_due = 0;
  int          frames_dropped = 0;
  int          bytes_checked = 0;
  int          error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 4;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  logic [1:0]  stall_phase = '0;
  tx_beat_t    head_beat;
  tx_beat_t    seen_beat;

  function automatic void log_error(input string what);
    error_count++;
    if (error_count <= MAX_SHOWN) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic logic [39:0] rand_ts();
    logic [39:0] v;
    v[31:0] = $urandom;
    v[39:32] = 8'($urandom);
    return v;
  endfunction

  function automatic void clear_responder_state();
    cur_pan_id = '0;
    cur_own_addr = '0;
    cur_delay = rfr_pkg::REPLY_DELAY_RST;
    rx_pos = '0;
    rx_seq = '0;
    rx_pan = '0;
    rx_dst = '0;
    rx_src = '0;
    for (int i = 0; i < rfr_pkg::STORE_DEPTH; i++) begin
      rx_payload[i] = '0;
    end
  endfunction

  // Wraps a body in header and zero CRC and queues every byte of the frame.
  function automatic void queue_tx_frame(input logic [7:0] seq, input logic [15:0] dst,
                                         input logic [7:0] body [rfr_pkg::BODY_BYTES],
                                         input int body_len, input logic [39:0] t);
    logic [7:0] frame [FRAME_MAX];
    int n;
    tx_beat_t beat;
    frame[0] = rfr_pkg::FC_WORD[7:0];
    frame[1] = rfr_pkg::FC_WORD[15:8];
    frame[2] = seq;
    frame[3] = cur_pan_id[7:0];
    frame[4] = cur_pan_id[15:8];
    frame[5] = dst[7:0];
    frame[6] = dst[15:8];
    frame[7] = cur_own_addr[7:0];
    frame[8] = cur_own_addr[15:8];
    n = rfr_pkg::HDR_BYTES;
    for (int i = 0; i < body_len; i++) begin
      frame[n] = body[i];
      n = n + 1;
    end
    frame[n] = 8'h00;
    frame[n + 1] = 8'h00;
    n = n + 2;
    for (int i = 0; i < n; i++) begin
      beat.tx_byte = frame[i];
      beat.tx_last = (i == n - 1);
      beat.tx_time = t;
      tx_bytes_due.push_back(beat);
    end
  endfunction

  // Works out what one accepted input transfer makes the responder send.
  function automatic void predict_tx(input logic cmd, input logic [7:0] rx_byte,
                                     input logic rx_last, input logic [39:0] ts);
    logic [39:0] tx_time;
    logic [7:0] body [rfr_pkg::BODY_BYTES];
    int frame_len;
    int keep;
    tx_time = ts + 40'(cur_delay);

    // An advertisement leaves the reception in progress untouched.
    if (cmd) begin
      for (int k = 0; k < rfr_pkg::TS_BYTES; k++) begin
        body[k] = tx_time[39 - 8 * k -: 8];
      end
      queue_tx_frame(8'h00, rfr_pkg::BCAST_ADDR, body, rfr_pkg::TS_BYTES, tx_time);
      adverts_due++;
      return;
    end

    // Capture header fields and the first payload bytes as they go by.
    case (rx_pos)
      rfr_pkg::POS_SEQ:    rx_seq = rx_byte;
      rfr_pkg::POS_PAN_LO: rx_pan[7:0] = rx_byte;
      rfr_pkg::POS_PAN_HI: rx_pan[15:8] = rx_byte;
      rfr_pkg::POS_DST_LO: rx_dst[7:0] = rx_byte;
      rfr_pkg::POS_DST_HI: rx_dst[15:8] = rx_byte;
      rfr_pkg::POS_SRC_LO: rx_src[7:0] = rx_byte;
      rfr_pkg::POS_SRC_HI: rx_src[15:8] = rx_byte;
      default: begin
        if (int'(rx_pos) >= int'(rfr_pkg::HDR_BYTES)
            && int'(rx_pos) < int'(rfr_pkg::HDR_BYTES + rfr_pkg::STORE_DEPTH)) begin
          rx_payload[int'(rx_pos) - int'(rfr_pkg::HDR_BYTES)] = rx_byte;
        end
      end
    endcase

    if (!rx_last) begin
      if (rx_pos != rfr_pkg::POS_MAX) begin
        rx_pos = rx_pos + 6'd1;
      end
      return;
    end

    // Last byte: filter on PAN, destination, sequence and length.
    frame_len = int'(rx_pos) + 1;
    rx_pos = '0;
    if (rx_pan != cur_pan_id || (rx_dst != cur_own_addr && rx_dst != rfr_pkg::BCAST_ADDR)) begin
      frames_dropped++;
      return;
    end
    if (rx_seq == rfr_pkg::SEQ_SHORT) begin
      keep = rfr_pkg::KEEP_SEQ0;
    end else if (rx_seq == rfr_pkg::SEQ_LONG) begin
      keep = rfr_pkg::KEEP_SEQ1;
    end else begin
      frames_dropped++;
      return;
    end
    if (frame_len < int'(rfr_pkg::HDR_BYTES) + keep + int'(rfr_pkg::CRC_BYTES)) begin
      frames_dropped++;
      return;
    end

    // Reply body: kept payload, then receive and reply times, big-endian.
    for (int i = 0; i < keep; i++) begin
      body[i] = rx_payload[i];
    end
    for (int k = 0; k < rfr_pkg::TS_BYTES; k++) begin
      body[keep + k] = ts[39 - 8 * k -: 8];
      body[keep + rfr_pkg::TS_BYTES + k] = tx_time[39 - 8 * k -: 8];
    end
    queue_tx_frame(rx_seq + 8'd1, rx_src, body, keep + 2 * rfr_pkg::TS_BYTES, tx_time);
    replies_due++;
  endfunction

  // Sends one input transfer, in bursts with random gaps between them.
  task automatic send_item(input logic cmd, input logic [7:0] rx_byte, input logic rx_last,
                           input logic [39:0] ts);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left = burst_left - 1;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tlast <= rx_last;
    in_tdata <= {ts, rx_byte};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    predict_tx(cmd, rx_byte, rx_last, ts);
  endtask

  task automatic send_advert(input logic [39:0] ts);
    send_item(1'b1, 8'($urandom), 1'($urandom), ts);
  endtask

  // Sends a whole received frame; an advertisement may be slipped in before one byte.
  task automatic send_frame(input logic [7:0] seq, input logic [15:0] pan,
                            input logic [15:0] dst, input logic [15:0] src,
                            input int frame_len, input logic [39:0] ts, input int advert_at);
    logic [7:0] hdr [rfr_pkg::HDR_BYTES];
    logic [7:0] b;
    logic is_last;
    hdr[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : rfr_pkg::FC_WORD[7:0];
    hdr[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : rfr_pkg::FC_WORD[15:8];
    hdr[2] = seq;
    hdr[3] = pan[7:0];
    hdr[4] = pan[15:8];
    hdr[5] = dst[7:0];
    hdr[6] = dst[15:8];
    hdr[7] = src[7:0];
    hdr[8] = src[15:8];
    for (int i = 0; i < frame_len; i++) begin
      if (i == advert_at) begin
        send_advert(rand_ts());
      end
      if (i < int'(rfr_pkg::HDR_BYTES)) begin
        b = hdr[i];
      end else begin
        b = 8'($urandom);
      end
      is_last = (i == frame_len - 1);
      send_item(1'b0, b, is_last, is_last ? ts : rand_ts());
    end
  endtask

  // Waits until every predicted transfer has arrived and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tx_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfr_pkg::REG_PAN_ID:      cur_pan_id = value[15:0];
      rfr_pkg::REG_OWN_ADDRESS: cur_own_addr = value[15:0];
      rfr_pkg::REG_REPLY_DELAY: cur_delay = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] pan, input logic [15:0] own,
                            input logic [31:0] delay);
    settle();
    write_reg(rfr_pkg::REG_PAN_ID, {16'h0000, pan});
    write_reg(rfr_pkg::REG_OWN_ADDRESS, {16'h0000, own});
    write_reg(rfr_pkg::REG_REPLY_DELAY, delay);
  endtask

  // Registers at their reset values: PAN 0, address 0, delay 1000.
  task automatic test_reset_defaults();
    send_frame(rfr_pkg::SEQ_SHORT, 16'h0000, 16'h0000, 16'h1234, 16, 40'h00_0000_0000,
               NO_ADVERT);
    send_advert(40'h00_0000_0000);
  endtask

  // Register extremes, including time wrap at 2^40.
  task automatic test_register_extremes();
    set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_frame(rfr_pkg::SEQ_SHORT, 16'hFFFF, 16'hFFFF, 16'h0000, 16, 40'hFF_FFFF_FFFF,
               NO_ADVERT);
    send_advert(40'hFF_FFFF_FFFF);
    set_config(16'h0000, 16'h0000, 32'h0000_0000);
    send_frame(rfr_pkg::SEQ_SHORT, 16'h0000, 16'h0000, 16'hFFFF, 16, 40'hFF_FFFF_FFFF,
               NO_ADVERT);
  endtask

  // Frames that must produce nothing.
  task automatic test_dropped_frames();
    set_config(16'h5A3C, 16'hC3A5, 32'h0000_0001);
    send_frame(rfr_pkg::SEQ_SHORT, 16'h5A3D, 16'hC3A5, 16'h0002, 16, rand_ts(), NO_ADVERT);
    send_frame(rfr_pkg::SEQ_SHORT, 16'h5A3C, 16'hC3A4, 16'h0002, 16, rand_ts(), NO_ADVERT);
    send_frame(8'd2, 16'h5A3C, 16'hC3A5, 16'h0002, 16, rand_ts(), NO_ADVERT);
    send_frame(rfr_pkg::SEQ_SHORT, 16'h5A3C, 16'hC3A5, 16'h0002, 15, rand_ts(), NO_ADVERT);
    send_frame(rfr_pkg::SEQ_LONG, 16'h5A3C, 16'hC3A5, 16'h0002, 25, rand_ts(), NO_ADVERT);
    send_frame(rfr_pkg::SEQ_SHORT, 16'h5A3C, 16'hC3A5, 16'h0002, 1, rand_ts(), NO_ADVERT);
  endtask

  // Long frame: extra payload ignored, byte count saturating.
  task automatic test_long_frames();
    send_frame(rfr_pkg::SEQ_LONG, 16'h5A3C, rfr_pkg::BCAST_ADDR, 16'h7E7E, 65, rand_ts(),
               NO_ADVERT);
  endtask

  // An advertisement arriving in the middle of a reception.
  task automatic test_advert_during_rx();
    send_frame(rfr_pkg::SEQ_LONG, 16'h5A3C, 16'hC3A5, 16'h4242, 26, rand_ts(), 4);
  endtask

  // Receiver stalls, switching between free running, coin flips, a fixed pattern
  // and heavy back-pressure.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 2'd1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom);
      2: out_tready <= (stall_phase != 2'd3);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each output transfer with the oldest predicted byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      seen_beat.tx_byte = out_tdata[7:0];
      seen_beat.tx_last = out_tlast;
      seen_beat.tx_time = out_tdata[47:8];
      if (tx_bytes_due.size() == 0) begin
        log_error($sformatf("unexpected transfer: byte %02h last %0d time %010h",
                            seen_beat.tx_byte, seen_beat.tx_last, seen_beat.tx_time));
      end else begin
        head_beat = tx_bytes_due.pop_front();
        if (seen_beat.tx_byte !== head_beat.tx_byte || seen_beat.tx_last !== head_beat.tx_last ||
            seen_beat.tx_time !== head_beat.tx_time) begin
          log_error($sformatf({"mismatch: expected byte %02h last %0d time %010h, ",
                               "got byte %02h last %0d time %010h"},
                              head_beat.tx_byte, head_beat.tx_last, head_beat.tx_time,
                              seen_beat.tx_byte, seen_beat.tx_last, seen_beat.tx_time));
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("ranging_frame_responder_test: done, errors");
    $finish;
  end

  initial begin
    clear_responder_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_dropped_frames();
    test_long_frames();
    test_advert_during_rx();
    settle();

    if (tx_bytes_due.size() != 0) begin
      log_error($sformatf("%0d predicted transfers never arrived", tx_bytes_due.size()));
    end
    $display("Sent %0d input transfers: %0d replies, %0d advertisements, %0d frames dropped.",
             items_sent, replies_due, adverts_due, frames_dropped);
    $display("Checked %0d output transfers, %0d errors.", bytes_checked, error_count);
    if (error_count == 0) begin
      $display("ranging_frame_responder_test: done, clean");
    end else begin
      $display("ranging_frame_responder_test: done, errors");
    end
    $finish;
  end

endmodule
